// File: hdl/albc_pkg.sv
`timescale 1ns / 1ps
// albc_pkg: shared types and constants of the ambient LED brightness control unit.
// Used by albc_engine and ambient_led_brightness_control_unit; no dependencies.
package albc_pkg;

    localparam int S_TDATA_W = 168;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    localparam logic [15:0] FULL_LEVEL   = 16'hFFFF;
    localparam logic [16:0] HYST_BAND    = 17'd131;
    localparam logic [12:0] HOLD_UNIT_MS = 13'd5000;
    localparam logic [23:0] ACC_WSQ      = 24'd14630625;   // 3825 squared
    localparam logic [23:0] GYRO_WSQ     = 24'd10653696;   // 3264 squared

    typedef enum logic [2:0] {
        MODE_OFF        = 3'd0,
        MODE_ON         = 3'd1,
        MODE_ADC_ONOFF  = 3'd2,
        MODE_ADC_SCALED = 3'd3,
        MODE_LUX_ONOFF  = 3'd4,
        MODE_LUX_SCALED = 3'd5,
        MODE_MOTION     = 3'd6,
        MODE_BAD        = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ADC_MISS   = 3'd1,
        ST_LUX_MISS   = 3'd2,
        ST_MOTION_MISS = 3'd3,
        ST_BAD_MODE   = 3'd4
    } status_t;

    typedef enum logic {
        ENG_SCALE  = 1'b0,
        ENG_MOTION = 1'b1
    } eng_kind_t;

    typedef struct packed {
        eng_kind_t        kind;
        logic [15:0]      ambient;
        logic [7:0]       min_amb;
        logic [7:0]       max_amb;
        logic [7:0]       min_led;
        logic [7:0]       max_led;
        logic [5:0][15:0] dabs;      // |delta| acc x,y,z then gyro x,y,z
    } eng_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] level;
        logic [29:0] trig;
    } eng_rsp_t;

endpackage

// File: hdl/ambient_led_brightness_control_unit.sv
`timescale 1ns / 1ps
// ambient_led_brightness_control_unit: top level, APB registers, stream ports, mode logic.
// Depends on albc_pkg and albc_engine.
//
//  channel  | direction | handshake          | content
//  ---------+-----------+--------------------+---------------------------------------
//  s_       | in        | s_tvalid/s_tready  | one brightness request word
//  m_       | out       | m_tvalid/m_tready  | brightness and status word
//  apb      | in        | psel/penable       | seven 8-bit (mode 3-bit) registers
//
// One word at a time. Fixed and on/off results pass through ST_EVAL and ST_EMIT to m_tvalid.
// Scaled modes also wait in ST_CALC, where albc_engine may run its 16-step restoring divider.
// Motion mode waits in ST_CALC for six squarings and two 29-step square roots.
// Reset (aresetn low, synchronous) restores register defaults and clears the control state.
// A finished word waits in the output register; s_tready returns as soon as it is loaded.
module ambient_led_brightness_control_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // [0] sensor_ready, [1] read_ok
    input  logic [albc_pkg::S_TUSER_W-1:0]  s_tuser,
    // [15:0] adc_level, [32:16] lux_half, [48:33] acc_x, [64:49] acc_y,
    // [80:65] acc_z, [96:81] gyro_x, [112:97] gyro_y, [128:113] gyro_z,
    // [160:129] now_ms, [167:161] zero
    input  logic [albc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] brightness, [18:16] status, [23:19] zero
    output logic [albc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [4:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import albc_pkg::*;

    typedef enum logic [2:0] {
        R_MODE, R_THRESHOLD, R_MIN_AMB, R_MAX_AMB, R_MIN_LED, R_MAX_LED, R_HOLD, R_NONE
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_EVAL, ST_CALC, ST_EMIT
    } state_t;

    // configuration
    mode_t       mode_reg;
    logic [7:0]  thr_reg, mina_reg, maxa_reg, minl_reg, maxl_reg, hold_reg;
    reg_idx_t    ridx;
    logic        apb_wr;

    // control and state
    state_t      state_reg;
    logic        m_tvalid_reg;
    logic [15:0] out_level_reg;
    status_t     out_status_reg;
    logic [15:0] res_level_reg;
    status_t     res_status_reg;
    logic [15:0] last_level_reg;
    logic [15:0] prev_acc_reg [3];
    logic [15:0] prev_gyro_reg [3];
    logic [31:0] stamp_reg;

    // latched request
    logic        rdy_reg, rok_reg;
    logic [15:0] adc_reg;
    logic [16:0] lux_reg;
    logic [15:0] acc_reg [3];
    logic [15:0] gyro_reg [3];
    logic [31:0] now_reg;

    // evaluation
    logic [18:0] lux3;
    logic [15:0] lux_amb;
    logic [15:0] thr16;
    logic        adc_low, adc_high, lux_low, lux_high;
    logic [15:0] ev_level;
    status_t     ev_status;
    logic        ev_calc;
    eng_req_t    eng_req;
    eng_rsp_t    eng_rsp;
    logic        eng_start;
    logic [16:0] dacc [3];
    logic [16:0] dgyr [3];
    logic [31:0] elapsed;
    logic [20:0] hold_lim;
    logic [15:0] motion_level;

    function automatic logic below_band(input logic [15:0] a, input logic [15:0] t);
        return ({1'b0, a} + HYST_BAND) < {1'b0, t};
    endfunction

    function automatic logic above_band(input logic [15:0] a, input logic [15:0] t);
        return {1'b0, a} > ({1'b0, t} + HYST_BAND);
    endfunction

    // APB
    assign pready = 1'b1;
    assign ridx   = reg_idx_t'(paddr[4:2]);
    assign apb_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (ridx)
            R_MODE:      prdata = {29'b0, mode_reg};
            R_THRESHOLD: prdata = {24'b0, thr_reg};
            R_MIN_AMB:   prdata = {24'b0, mina_reg};
            R_MAX_AMB:   prdata = {24'b0, maxa_reg};
            R_MIN_LED:   prdata = {24'b0, minl_reg};
            R_MAX_LED:   prdata = {24'b0, maxl_reg};
            R_HOLD:      prdata = {24'b0, hold_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_OFF;
            thr_reg  <= 8'd0;
            mina_reg <= 8'd0;
            maxa_reg <= 8'd255;
            minl_reg <= 8'd0;
            maxl_reg <= 8'd255;
            hold_reg <= 8'd0;
        end else if (apb_wr) begin
            case (ridx)
                R_MODE:      mode_reg <= mode_t'(pwdata[2:0]);
                R_THRESHOLD: thr_reg  <= pwdata[7:0];
                R_MIN_AMB:   mina_reg <= pwdata[7:0];
                R_MAX_AMB:   maxa_reg <= pwdata[7:0];
                R_MIN_LED:   minl_reg <= pwdata[7:0];
                R_MAX_LED:   maxl_reg <= pwdata[7:0];
                R_HOLD:      hold_reg <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    // mode evaluation
    assign lux3     = {2'b0, lux_reg} + {1'b0, lux_reg, 1'b0};
    assign lux_amb  = (lux3[18:16] != '0) ? FULL_LEVEL : lux3[15:0];
    assign thr16    = {thr_reg, thr_reg};
    assign adc_low  = below_band(adc_reg, thr16);
    assign adc_high = above_band(adc_reg, thr16);
    assign lux_low  = below_band(lux_amb, thr16);
    assign lux_high = above_band(lux_amb, thr16);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dacc[i] = {acc_reg[i][15], acc_reg[i]} - {prev_acc_reg[i][15], prev_acc_reg[i]};
            dgyr[i] = {gyro_reg[i][15], gyro_reg[i]}
                    - {prev_gyro_reg[i][15], prev_gyro_reg[i]};
            eng_req.dabs[i]     = dacc[i][16] ? 16'(-dacc[i]) : dacc[i][15:0];
            eng_req.dabs[i + 3] = dgyr[i][16] ? 16'(-dgyr[i]) : dgyr[i][15:0];
        end
        eng_req.min_amb = mina_reg;
        eng_req.max_amb = maxa_reg;
        eng_req.min_led = minl_reg;
        eng_req.max_led = maxl_reg;
        eng_req.kind    = ENG_SCALE;
        eng_req.ambient = adc_reg;
        ev_level        = last_level_reg;
        ev_status       = ST_OK;
        ev_calc         = 1'b0;
        case (mode_reg)
            MODE_OFF: ev_level = 16'h0000;
            MODE_ON:  ev_level = FULL_LEVEL;
            MODE_ADC_ONOFF, MODE_ADC_SCALED: begin
                if (!rdy_reg) begin
                    ev_level  = FULL_LEVEL;
                    ev_status = ST_ADC_MISS;
                end else if (adc_low) begin
                    ev_level = 16'h0000;
                end else if (adc_high) begin
                    if (mode_reg == MODE_ADC_ONOFF) begin
                        ev_level = FULL_LEVEL;
                    end else begin
                        ev_calc = 1'b1;
                    end
                end
            end
            MODE_LUX_ONOFF, MODE_LUX_SCALED: begin
                eng_req.ambient = lux_amb;
                if (!rdy_reg) begin
                    ev_level  = FULL_LEVEL;
                    ev_status = ST_LUX_MISS;
                end else if (!rok_reg) begin
                    ev_level  = 16'h0000;
                    ev_status = ST_LUX_MISS;
                end else if (lux_high) begin
                    ev_level = 16'h0000;
                end else if (lux_low) begin
                    if (mode_reg == MODE_LUX_ONOFF) begin
                        ev_level = FULL_LEVEL;
                    end else begin
                        ev_calc = 1'b1;
                    end
                end
            end
            MODE_MOTION: begin
                eng_req.kind = ENG_MOTION;
                if (!rdy_reg) begin
                    ev_level  = FULL_LEVEL;
                    ev_status = ST_MOTION_MISS;
                end else begin
                    ev_calc = 1'b1;
                end
            end
            default: begin
                ev_level  = FULL_LEVEL;
                ev_status = ST_BAD_MODE;
            end
        endcase
    end

    assign eng_start = (state_reg == ST_EVAL) && ev_calc;

    albc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (eng_start),
        .req     (eng_req),
        .rsp     (eng_rsp)
    );

    assign elapsed  = now_reg - stamp_reg;
    assign hold_lim = 21'(hold_reg) * 21'(HOLD_UNIT_MS);

    always_comb begin
        if (eng_rsp.trig > {10'b0, thr_reg, 12'b0}) begin
            motion_level = FULL_LEVEL;
        end else if (elapsed > {11'b0, hold_lim}) begin
            motion_level = 16'h0000;
        end else begin
            motion_level = last_level_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_status_reg, out_level_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            last_level_reg <= '0;
            stamp_reg      <= '0;
            for (int i = 0; i < 3; i++) begin
                prev_acc_reg[i]  <= '0;
                prev_gyro_reg[i] <= '0;
            end
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        rdy_reg     <= s_tuser[0];
                        rok_reg     <= s_tuser[1];
                        adc_reg     <= s_tdata[15:0];
                        lux_reg     <= s_tdata[32:16];
                        acc_reg[0]  <= s_tdata[48:33];
                        acc_reg[1]  <= s_tdata[64:49];
                        acc_reg[2]  <= s_tdata[80:65];
                        gyro_reg[0] <= s_tdata[96:81];
                        gyro_reg[1] <= s_tdata[112:97];
                        gyro_reg[2] <= s_tdata[128:113];
                        now_reg     <= s_tdata[160:129];
                        state_reg   <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    res_level_reg  <= ev_level;
                    res_status_reg <= ev_status;
                    if (ev_calc) begin
                        if (mode_reg == MODE_MOTION) begin
                            for (int i = 0; i < 3; i++) begin
                                prev_acc_reg[i]  <= acc_reg[i];
                                prev_gyro_reg[i] <= gyro_reg[i];
                            end
                        end
                        state_reg <= ST_CALC;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_CALC: begin
                    if (eng_rsp.done) begin
                        if (mode_reg == MODE_MOTION) begin
                            res_level_reg <= motion_level;
                            if (eng_rsp.trig > {10'b0, thr_reg, 12'b0}) begin
                                stamp_reg <= now_reg;
                            end
                        end else begin
                            res_level_reg <= eng_rsp.level;
                        end
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg   <= 1'b1;
                        out_level_reg  <= res_level_reg;
                        out_status_reg <= res_status_reg;
                        last_level_reg <= res_level_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/albc_engine.sv
`timescale 1ns / 1ps
// albc_engine: multi-cycle arithmetic for the scaled modes and the motion trigger.
// One shared 17x24 multiplier; divide and square root each have their own shift/subtract step.
// Depends on albc_pkg.
module albc_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  albc_pkg::eng_req_t req,
    output albc_pkg::eng_rsp_t rsp
);
    import albc_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE, E_SINIT, E_DIV, E_SMUL, E_SFIN,
        E_MSQ, E_MACC, E_WLO, E_WLOA, E_WHI, E_WHIA, E_ROOT
    } estate_t;

    estate_t     state_reg;
    logic [15:0] amb_reg;
    logic [7:0]  mina_reg, maxa_reg, minl_reg, maxl_reg;
    logic [15:0] dabs_reg [6];
    logic [31:0] rem_reg;
    logic [28:0] root_reg;
    logic [28:0] root0_reg;
    logic [57:0] rad_reg;
    logic [15:0] divr_reg;
    logic [15:0] ratio_reg;
    logic [4:0]  cnt_reg;
    logic [2:0]  idx_reg;
    logic        which_reg;
    logic [33:0] sa_reg, sg_reg;
    logic [40:0] mul_reg;
    logic [15:0] level_reg;
    logic [29:0] trig_reg;
    logic        done_reg;

    // shared multiplier
    logic [16:0] mul_a;
    logic [23:0] mul_b;
    logic [33:0] wsrc;
    logic [23:0] wconst;

    // scale set-up
    logic [16:0] num, den;
    logic [15:0] num_abs, den_abs;
    logic [31:0] div_n;
    logic [16:0] div_r2;
    logic        div_bit;

    // square root step
    logic [31:0] sq_r4, sq_trial;
    logic        sq_bit;
    logic [28:0] root_new;

    // final scale
    logic        span_neg;
    logic [15:0] span_abs;
    logic [16:0] q_sum, q_fin;
    logic [17:0] lo_led, led;

    assign wsrc   = which_reg ? sg_reg : sa_reg;
    assign wconst = which_reg ? GYRO_WSQ : ACC_WSQ;

    assign span_neg = maxl_reg < minl_reg;
    assign span_abs = span_neg ? ({minl_reg, minl_reg} - {maxl_reg, maxl_reg})
                               : ({maxl_reg, maxl_reg} - {minl_reg, minl_reg});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            E_MSQ: begin
                mul_a = {1'b0, dabs_reg[idx_reg]};
                mul_b = {8'b0, dabs_reg[idx_reg]};
            end
            E_WLO: begin
                mul_a = wsrc[16:0];
                mul_b = wconst;
            end
            E_WHI: begin
                mul_a = wsrc[33:17];
                mul_b = wconst;
            end
            E_SMUL: begin
                mul_a = {1'b0, ratio_reg};
                mul_b = {8'b0, span_abs};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        num     = {1'b0, amb_reg} - {1'b0, mina_reg, mina_reg};
        den     = {1'b0, maxa_reg, maxa_reg} - {1'b0, mina_reg, mina_reg};
        num_abs = num[16] ? 16'(-num) : num[15:0];
        den_abs = den[16] ? 16'(-den) : den[15:0];
        div_n   = {num_abs, 16'b0} - {16'b0, num_abs};
    end

    assign div_r2  = {rem_reg[15:0], rad_reg[15]};
    assign div_bit = div_r2 >= {1'b0, divr_reg};

    assign sq_r4    = {rem_reg[29:0], rad_reg[57:56]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_bit   = sq_r4 >= sq_trial;
    assign root_new = {root_reg[27:0], sq_bit};

    // divide by 65535: x = q*65536 + r = q*65535 + (q + r)
    always_comb begin
        q_sum = {1'b0, mul_reg[31:16]} + {1'b0, mul_reg[15:0]};
        if (q_sum >= 17'd131070) begin
            q_fin = {1'b0, mul_reg[31:16]} + 17'd2;
        end else if (q_sum >= 17'd65535) begin
            q_fin = {1'b0, mul_reg[31:16]} + 17'd1;
        end else begin
            q_fin = {1'b0, mul_reg[31:16]};
        end
        lo_led = {2'b0, minl_reg, minl_reg};
        led    = span_neg ? (lo_led - {1'b0, q_fin}) : (lo_led + {1'b0, q_fin});
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == E_SFIN)
                     || ((state_reg == E_ROOT) && (cnt_reg == '0) && which_reg);
            case (state_reg)
                E_IDLE: begin
                    if (start) begin
                        amb_reg  <= req.ambient;
                        mina_reg <= req.min_amb;
                        maxa_reg <= req.max_amb;
                        minl_reg <= req.min_led;
                        maxl_reg <= req.max_led;
                        for (int i = 0; i < 6; i++) begin
                            dabs_reg[i] <= req.dabs[i];
                        end
                        idx_reg   <= '0;
                        sa_reg    <= '0;
                        sg_reg    <= '0;
                        which_reg <= 1'b0;
                        state_reg <= (req.kind == ENG_MOTION) ? E_MSQ : E_SINIT;
                    end
                end
                E_SINIT: begin
                    rem_reg        <= {16'b0, div_n[31:16]};
                    rad_reg[15:0]  <= div_n[15:0];
                    divr_reg       <= den_abs;
                    cnt_reg        <= 5'd15;
                    if (den == '0) begin
                        ratio_reg <= num[16] ? 16'h0000 : FULL_LEVEL;
                        state_reg <= E_SMUL;
                    end else if (!den[16]) begin
                        if (num[16] || num == '0) begin
                            ratio_reg <= 16'h0000;
                            state_reg <= E_SMUL;
                        end else if ($signed(num) >= $signed(den)) begin
                            ratio_reg <= FULL_LEVEL;
                            state_reg <= E_SMUL;
                        end else begin
                            state_reg <= E_DIV;
                        end
                    end else begin
                        if (!num[16]) begin
                            ratio_reg <= 16'h0000;
                            state_reg <= E_SMUL;
                        end else if ($signed(num) <= $signed(den)) begin
                            ratio_reg <= FULL_LEVEL;
                            state_reg <= E_SMUL;
                        end else begin
                            state_reg <= E_DIV;
                        end
                    end
                end
                E_DIV: begin
                    rem_reg       <= div_bit ? {15'b0, div_r2 - {1'b0, divr_reg}}
                                             : {15'b0, div_r2};
                    rad_reg[15:0] <= {rad_reg[14:0], div_bit};
                    cnt_reg       <= cnt_reg - 5'd1;
                    if (cnt_reg == '0) begin
                        ratio_reg <= {rad_reg[14:0], div_bit};
                        state_reg <= E_SMUL;
                    end
                end
                E_SMUL: begin
                    state_reg <= E_SFIN;
                end
                E_SFIN: begin
                    if (led[17]) begin
                        level_reg <= 16'h0000;
                    end else if (led[16]) begin
                        level_reg <= FULL_LEVEL;
                    end else begin
                        level_reg <= led[15:0];
                    end
                    state_reg <= E_IDLE;
                end
                E_MSQ: begin
                    state_reg <= E_MACC;
                end
                E_MACC: begin
                    if (idx_reg < 3'd3) begin
                        sa_reg <= sa_reg + mul_reg[33:0];
                    end else begin
                        sg_reg <= sg_reg + mul_reg[33:0];
                    end
                    if (idx_reg == 3'd5) begin
                        state_reg <= E_WLO;
                    end else begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= E_MSQ;
                    end
                end
                E_WLO: begin
                    state_reg <= E_WLOA;
                end
                E_WLOA: begin
                    rad_reg   <= {17'b0, mul_reg};
                    state_reg <= E_WHI;
                end
                E_WHI: begin
                    state_reg <= E_WHIA;
                end
                E_WHIA: begin
                    rad_reg   <= rad_reg + {mul_reg, 17'b0};
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= 5'd28;
                    state_reg <= E_ROOT;
                end
                E_ROOT: begin
                    rem_reg  <= sq_bit ? (sq_r4 - sq_trial) : sq_r4;
                    root_reg <= root_new;
                    rad_reg  <= {rad_reg[55:0], 2'b00};
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == '0) begin
                        if (!which_reg) begin
                            root0_reg <= root_new;
                            which_reg <= 1'b1;
                            state_reg <= E_WLO;
                        end else begin
                            trig_reg  <= {1'b0, root0_reg} + {1'b0, root_new};
                            state_reg <= E_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.level = level_reg;
    assign rsp.trig  = trig_reg;

endmodule
